/* hw/rtl/emg_time_domain_features_core_assert.svh */
// Assertion macros shared by the feature extractor RTL.
`ifndef EMG_TIME_DOMAIN_FEATURES_CORE_ASSERT_SVH
`define EMG_TIME_DOMAIN_FEATURES_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define EMG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define EMG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

/* hw/rtl/emg_tdf_pkg.sv */
// Shared constants and types of the EMG time-domain feature extractor.
package emg_tdf_pkg;

  localparam int CHANNELS   = 4;
  localparam int MAX_WINDOW = 4096;
  localparam int MIN_WINDOW = 3;

  localparam int SAMPLE_W   = 24;
  localparam int POS_W      = 12;
  localparam int WIN_W      = 13;
  localparam int SUM_W      = 36;
  localparam int LEN_W      = 37;
  localparam int CNT_W      = 12;
  localparam int THR_W      = 23;
  localparam int QUO_W      = 24;
  localparam int RATE_W     = 16;
  localparam int CH_W       = 2;
  localparam int ITER_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESHOLD = 2'd2;

  // Register reset values.
  localparam logic [WIN_W-1:0] WINDOW_RESET    = 13'd150;
  localparam logic [THR_W-1:0] DEAD_ZONE_RESET = 23'd210;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 23'd1258;

  // Per-cycle control that the sequencer sends to every lane.
  typedef struct packed {
    logic accept;
    logic pair_en;
    logic turn_en;
    logic load;
    logic step;
  } lane_ctrl_t;

  // Window features that one lane hands to the merge stage.
  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [QUO_W-1:0]    length;
    logic [RATE_W-1:0]   crossing;
    logic [RATE_W-1:0]   turn;
  } lane_result_t;

endpackage

/* hw/rtl/emg_tdf_if.sv */
// Stream interfaces for the sample input and the feature output.
interface emg_tdf_in_if;
  import emg_tdf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_ch0;
  logic signed [SAMPLE_W-1:0] sample_ch1;
  logic signed [SAMPLE_W-1:0] sample_ch2;
  logic signed [SAMPLE_W-1:0] sample_ch3;
  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  input ready);
  modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                output ready);
endinterface

interface emg_tdf_out_if;
  import emg_tdf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] mean_value;
  logic [QUO_W-1:0]           length_rate;
  logic [RATE_W-1:0]          crossing_rate;
  logic [RATE_W-1:0]          turn_rate;
  logic                       last;
  modport source (output valid, channel, mean_value, length_rate, crossing_rate,
                  turn_rate, last, input ready);
  modport sink (input valid, channel, mean_value, length_rate, crossing_rate,
                turn_rate, last, output ready);
endinterface

/* hw/rtl/emg_tdf_lane.sv */
// One channel lane: window accumulators and four bit-serial dividers.
module emg_tdf_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  emg_tdf_pkg::lane_ctrl_t              ctrl,
  input  logic signed [emg_tdf_pkg::SAMPLE_W-1:0] sample,
  input  logic [emg_tdf_pkg::THR_W-1:0]        dead_zone,
  input  logic [emg_tdf_pkg::THR_W-1:0]        turn_threshold,
  input  logic [emg_tdf_pkg::WIN_W-1:0]        divisor,
  output emg_tdf_pkg::lane_result_t            result
);
  import emg_tdf_pkg::*;

  localparam int NQ = 4;

  logic signed [SAMPLE_W-1:0] previous_sample;
  logic signed [SAMPLE_W-1:0] older_sample;
  logic signed [SUM_W-1:0]    sample_sum;
  logic [LEN_W-1:0]           length_total;
  logic [CNT_W-1:0]           crossing_count;
  logic [CNT_W-1:0]           turn_count;
  logic                       mean_neg;

  logic [WIN_W-1:0] rem [NQ];
  logic [QUO_W-1:0] quo [NQ];

  logic signed [SAMPLE_W:0] x_ext, a_ext, o_ext, dz_s, diff_ax, diff_ao;
  logic [SAMPLE_W-1:0]      abs_ax, abs_ao;
  logic                     opposite, both_dead, extremum, big_step;
  logic [SUM_W-1:0]         sum_mag;
  logic [LEN_W-1:0]         dividend [NQ];
  logic [QUO_W-1:0]         mean_mag;

  // Sample comparisons for crossings, length and turns.
  always_comb begin
    x_ext     = {sample[SAMPLE_W-1], sample};
    a_ext     = {previous_sample[SAMPLE_W-1], previous_sample};
    o_ext     = {older_sample[SAMPLE_W-1], older_sample};
    dz_s      = $signed({2'b00, dead_zone});
    diff_ax   = a_ext - x_ext;
    diff_ao   = a_ext - o_ext;
    abs_ax    = diff_ax[SAMPLE_W] ? SAMPLE_W'(-diff_ax) : diff_ax[SAMPLE_W-1:0];
    abs_ao    = diff_ao[SAMPLE_W] ? SAMPLE_W'(-diff_ao) : diff_ao[SAMPLE_W-1:0];
    opposite  = (a_ext > 0 && x_ext < 0) || (a_ext < 0 && x_ext > 0);
    both_dead = (a_ext > -dz_s) && (a_ext < dz_s) && (x_ext > -dz_s) && (x_ext < dz_s);
    extremum  = (a_ext > o_ext && a_ext > x_ext) || (a_ext < o_ext && a_ext < x_ext);
    big_step  = (abs_ao > {1'b0, turn_threshold}) || (abs_ax > {1'b0, turn_threshold});
  end

  // Dividends; every quotient fits in QUO_W bits, so the top bits start below the divisor.
  always_comb begin
    sum_mag     = sample_sum[SUM_W-1] ? SUM_W'(-sample_sum) : SUM_W'(sample_sum);
    dividend[0] = {1'b0, sum_mag};
    dividend[1] = length_total;
    dividend[2] = {9'd0, crossing_count, 16'd0};
    dividend[3] = {9'd0, turn_count, 16'd0};
  end

  // Window accumulators, cleared when their contents move into the dividers.
  always_ff @(posedge clk) begin
    if (rst || ctrl.load) begin
      previous_sample <= '0;
      older_sample    <= '0;
      sample_sum      <= '0;
      length_total    <= '0;
      crossing_count  <= '0;
      turn_count      <= '0;
    end else if (ctrl.accept) begin
      sample_sum <= sample_sum + SUM_W'(sample);
      if (ctrl.pair_en) begin
        length_total <= length_total + LEN_W'(abs_ax);
        if (opposite && !both_dead) crossing_count <= crossing_count + 1'b1;
      end
      if (ctrl.turn_en && extremum && big_step) turn_count <= turn_count + 1'b1;
      older_sample    <= previous_sample;
      previous_sample <= sample;
    end
  end

  // Restoring division, one quotient bit per step for all four features.
  always_ff @(posedge clk) begin
    logic [WIN_W:0] trial;
    logic           ge;
    if (ctrl.load) begin
      mean_neg <= sample_sum[SUM_W-1];
    end
    for (int k = 0; k < NQ; k++) begin
      trial = {rem[k], quo[k][QUO_W-1]};
      ge    = trial >= {1'b0, divisor};
      if (ctrl.load) begin
        rem[k] <= dividend[k][LEN_W-1:QUO_W];
        quo[k] <= dividend[k][QUO_W-1:0];
      end else if (ctrl.step) begin
        rem[k] <= ge ? WIN_W'(trial - {1'b0, divisor}) : trial[WIN_W-1:0];
        quo[k] <= {quo[k][QUO_W-2:0], ge};
      end
    end
  end

  // Restore the sign of the mean.
  always_comb begin
    mean_mag        = quo[0];
    result.mean     = mean_neg ? SAMPLE_W'(-mean_mag) : mean_mag;
    result.length   = quo[1];
    result.crossing = quo[2][RATE_W-1:0];
    result.turn     = quo[3][RATE_W-1:0];
  end

endmodule

/* hw/rtl/emg_tdf_merge.sv */
// Merge stage: sends the lane results out one channel at a time.
module emg_tdf_merge (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               start,
  input  emg_tdf_pkg::lane_result_t [emg_tdf_pkg::CHANNELS-1:0] results,
  output logic                                               done,
  emg_tdf_out_if.source                                      features
);
  import emg_tdf_pkg::*;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  logic            busy;
  logic [CH_W-1:0] idx;
  logic            load;

  // A result moves into the output register when it is empty or being drained.
  assign load = busy && (!features.valid || features.ready);
  assign done = load && (idx == LAST_CH);

  // Output register and channel sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      idx            <= '0;
      features.valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (load) begin
        idx <= idx + 1'b1;
        if (idx == LAST_CH) busy <= 1'b0;
      end
      if (load) begin
        features.valid <= 1'b1;
      end else if (features.ready) begin
        features.valid <= 1'b0;
      end
    end
  end

  // Payload of the output register.
  always_ff @(posedge clk) begin
    if (load) begin
      features.channel       <= idx;
      features.mean_value    <= results[idx].mean;
      features.length_rate   <= results[idx].length;
      features.crossing_rate <= results[idx].crossing;
      features.turn_rate     <= results[idx].turn;
      features.last          <= (idx == LAST_CH);
    end
  end

endmodule

/* hw/rtl/emg_time_domain_features_core.sv */
// Top level: configuration, window sequencing, channel lanes and merge stage.
// Mid-window sample: a new sample is taken each cycle.
// Window-end sample: a load step, then divide steps (one quotient bit per cycle in
// every lane), then four results enter the output register at one per cycle at best.
// Input ready stays low after a window-end transfer until the merge stage has loaded the last result.
// Synchronous active-high reset clears the window and restores register defaults.
module emg_time_domain_features_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [emg_tdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [emg_tdf_pkg::CFG_DATA_W-1:0]    cfg_data,
  emg_tdf_in_if.sink                            samples,
  emg_tdf_out_if.source                         features
);
  import emg_tdf_pkg::*;
  `include "emg_time_domain_features_core_assert.svh"

  typedef enum logic [1:0] {S_ACC, S_LOAD, S_DIV, S_OUT} state_t;

  state_t             state;
  logic [WIN_W-1:0]   window_length;
  logic [THR_W-1:0]   dead_zone;
  logic [THR_W-1:0]   turn_threshold;
  logic [POS_W-1:0]   position_in_window;
  logic [WIN_W-1:0]   divisor;
  logic [ITER_W-1:0]  iter;

  logic [WIN_W-1:0]   n_eff, p13;
  logic               in_xfer, win_end, merge_start, merge_done;
  lane_ctrl_t         ctrl;
  logic signed [SAMPLE_W-1:0] lane_sample [CHANNELS];
  lane_result_t [CHANNELS-1:0] results;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WINDOW_RESET;
      dead_zone      <= DEAD_ZONE_RESET;
      turn_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:  window_length  <= cfg_data[WIN_W-1:0];
        REG_DEAD_ZONE:      dead_zone      <= cfg_data[THR_W-1:0];
        REG_TURN_THRESHOLD: turn_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped window length and position tests.
  always_comb begin
    if (window_length < WIN_W'(MIN_WINDOW)) n_eff = WIN_W'(MIN_WINDOW);
    else if (window_length > WIN_W'(MAX_WINDOW)) n_eff = WIN_W'(MAX_WINDOW);
    else n_eff = window_length;
    p13            = {1'b0, position_in_window};
    samples.ready  = (state == S_ACC);
    in_xfer        = samples.valid && samples.ready;
    win_end        = (p13 + 1'b1) >= n_eff;
    ctrl.accept    = in_xfer;
    ctrl.pair_en   = (position_in_window != '0) && ((p13 + 2'd2) <= n_eff);
    ctrl.turn_en   = (position_in_window >= POS_W'(2)) && ((p13 + 1'b1) <= n_eff);
    ctrl.load      = (state == S_LOAD);
    ctrl.step      = (state == S_DIV);
    merge_start    = (state == S_DIV) && (iter == ITER_W'(QUO_W - 1));
  end

  // Window sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_ACC;
      position_in_window <= '0;
      iter               <= '0;
    end else begin
      case (state)
        S_ACC: begin
          if (in_xfer) begin
            if (win_end) begin
              divisor            <= p13 + 1'b1;
              position_in_window <= '0;
              state              <= S_LOAD;
            end else begin
              position_in_window <= position_in_window + 1'b1;
            end
          end
        end
        S_LOAD: begin
          iter  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          iter <= iter + 1'b1;
          if (merge_start) state <= S_OUT;
        end
        S_OUT: begin
          if (merge_done) state <= S_ACC;
        end
        default: state <= S_ACC;
      endcase
    end
  end

  assign lane_sample[0] = samples.sample_ch0;
  assign lane_sample[1] = samples.sample_ch1;
  assign lane_sample[2] = samples.sample_ch2;
  assign lane_sample[3] = samples.sample_ch3;

  // One lane per channel.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    emg_tdf_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .sample         (lane_sample[g]),
      .dead_zone      (dead_zone),
      .turn_threshold (turn_threshold),
      .divisor        (divisor),
      .result         (results[g])
    );
  end

  emg_tdf_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .start    (merge_start),
    .results  (results),
    .done     (merge_done),
    .features (features)
  );

  `EMG_ASSERT_NEXT(a_end_loads, clk, rst, in_xfer && win_end, state == S_LOAD)
  `EMG_ASSERT_NEXT(a_load_divides, clk, rst, state == S_LOAD, state == S_DIV && iter == '0)
  `EMG_ASSERT_SAME(a_iter_bound, clk, rst, state == S_DIV, iter < ITER_W'(QUO_W))
  `EMG_ASSERT_NEXT(a_div_ends, clk, rst, merge_start, state == S_OUT && !features.valid || state == S_OUT)

endmodule
